[rtl/qla_pkg.sv]
// Shared constants, codes and types of the tabular Q-learning agent.
package qla_pkg;

    localparam int STATE_COUNT   = 64;
    localparam int ACTION_COUNT  = 8;
    localparam int HISTORY_DEPTH = 32;
    localparam int Q_WIDTH       = 16;

    localparam int DRAW_W = 16;
    localparam int CNT_W  = 5;
    localparam int PADDR_W = 4;

    localparam logic [1:0] OP_CHOOSE = 2'd0;
    localparam logic [1:0] OP_REWARD = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] REG_LEARN_RATE   = 2'd0;
    localparam logic [1:0] REG_DISCOUNT     = 2'd1;
    localparam logic [1:0] REG_EXPLORE_RATE = 2'd2;

    localparam logic [15:0] LEARN_RATE_RST   = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST     = 16'd58982;
    localparam logic [15:0] EXPLORE_RATE_RST = 16'd6554;

    typedef struct packed {
        logic start;
        logic has_next;
        logic newest;
    } t_upd_ctl;

endpackage

[rtl/qla_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module qla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/qla_upd.sv]
// Four-stage pipeline computing one saturating Q value update.
module qla_upd #(
    parameter int Q_WIDTH = qla_pkg::Q_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  qla_pkg::t_upd_ctl          i_ctl,
    input  logic signed [Q_WIDTH-1:0]  i_cur,
    input  logic signed [Q_WIDTH-1:0]  i_rmax,
    input  logic signed [15:0]         i_reward,
    input  logic [15:0]                i_alpha,
    input  logic [15:0]                i_gamma,
    output logic                       o_done,
    output logic signed [Q_WIDTH-1:0]  o_q
);

    localparam int P1W = Q_WIDTH + 17;
    localparam int NW  = P1W - 16;
    localparam int RW  = (Q_WIDTH > 16) ? Q_WIDTH : 16;
    localparam int DW  = ((NW > RW) ? NW : RW) + 2;
    localparam int P2W = DW + 17;
    localparam int UW  = P2W - 16;
    localparam int SW  = UW + 1;
    localparam logic signed [SW-1:0] QMAX = SW'((longint'(1) <<< (Q_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] QMIN = -QMAX - SW'(1);

    logic [3:0]                r_v;
    logic signed [P1W-1:0]     r_p1;
    logic signed [RW-1:0]      r_r1;
    logic signed [Q_WIDTH-1:0] r_cur1;
    logic signed [Q_WIDTH-1:0] r_cur2;
    logic signed [Q_WIDTH-1:0] r_cur3;
    logic signed [DW-1:0]      r_delta;
    logic signed [P2W-1:0]     r_p2;
    logic signed [Q_WIDTH-1:0] r_q;

    logic signed [P1W-1:0]     w_p1r;
    logic signed [NW-1:0]      w_next;
    logic signed [P2W-1:0]     w_p2r;
    logic signed [UW-1:0]      w_u;
    logic signed [SW-1:0]      w_sum;
    logic signed [Q_WIDTH-1:0] w_sat;

    assign w_p1r  = (r_p1 + P1W'(32768)) >>> 16;
    assign w_next = w_p1r[NW-1:0];
    assign w_p2r  = (r_p2 + P2W'(32768)) >>> 16;
    assign w_u    = w_p2r[UW-1:0];
    assign w_sum  = SW'(r_cur3) + SW'(w_u);

    always_comb begin
        if (w_sum > QMAX) begin
            w_sat = QMAX[Q_WIDTH-1:0];
        end else if (w_sum < QMIN) begin
            w_sat = QMIN[Q_WIDTH-1:0];
        end else begin
            w_sat = w_sum[Q_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_ctl.start};
        end
        if (i_ctl.has_next) begin
            r_p1 <= P1W'($signed({1'b0, i_gamma})) * P1W'(i_rmax);
        end else begin
            r_p1 <= '0;
        end
        r_r1    <= i_ctl.newest ? RW'(i_reward) : '0;
        r_cur1  <= i_cur;
        r_delta <= DW'(r_r1) + DW'(w_next) - DW'(r_cur1);
        r_cur2  <= r_cur1;
        r_p2    <= P2W'($signed({1'b0, i_alpha})) * P2W'(r_delta);
        r_cur3  <= r_cur2;
        r_q     <= w_sat;
    end

    assign o_done = r_v[3];
    assign o_q    = r_q;

endmodule

[rtl/tabular_q_learning_agent_core.sv]
// Top level of the tabular Q-learning agent: control sequencer, memories and register port.
//
// After reset the block sweeps the Q table to zero, one entry a cycle; no item is accepted
// meanwhile, though register writes are. One item is processed at a time and the Q table
// has a single read port, which sets the timing. A clear item or an unused code goes
// straight to the done state. A choose item makes one Q read per action when it exploits
// and, when it explores, works out a 16-step remainder of the draw, then walks over the
// mask and stops at the picked action. A reward item handles the newest recorded step and
// then each older step: one history read, a row maximum over all actions (older steps
// only), one Q read, the four-stage update pipeline and a write back. A finished result
// waits in an output register, so the next item can be taken while the previous transfer
// is still stalled.
module tabular_q_learning_agent_core #(
    parameter int STATE_COUNT   = qla_pkg::STATE_COUNT,
    parameter int ACTION_COUNT  = qla_pkg::ACTION_COUNT,
    parameter int HISTORY_DEPTH = qla_pkg::HISTORY_DEPTH,
    parameter int Q_WIDTH       = qla_pkg::Q_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qla_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic [5:0]                  i_current_state,
    input  logic [7:0]                  i_legal_mask,
    input  logic [15:0]                 i_explore_roll,
    input  logic [15:0]                 i_explore_draw,
    input  logic signed [15:0]          i_reward_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_chosen_action,
    output logic                        o_status,
    output logic [5:0]                  o_updates_done
);

    localparam int QD  = STATE_COUNT * ACTION_COUNT;
    localparam int QAW = $clog2(QD);
    localparam int SB  = $clog2(STATE_COUNT);
    localparam int AB  = $clog2(ACTION_COUNT);
    localparam int CB  = $clog2(ACTION_COUNT + 1);
    localparam int TW  = SB + AB;
    localparam int HB  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int LB  = $clog2(HISTORY_DEPTH + 1);
    localparam int CW  = qla_pkg::CNT_W;
    localparam int DRW = qla_pkg::DRAW_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DIV, S_PICK, S_SCAN, S_SCAN_END, S_REC,
        S_RW_TRD, S_RW_TWAIT, S_RW_QRD, S_RW_QWAIT, S_RW_CALC, S_DONE
    } t_state;

    t_state                     r_state;
    logic [15:0]                r_learn_rate;
    logic [15:0]                r_discount;
    logic [15:0]                r_explore_rate;
    logic [QAW-1:0]             r_clr;
    logic [LB-1:0]              r_len;
    logic [HB-1:0]              r_step;
    logic [CW-1:0]              r_cnt;
    logic [SB-1:0]              r_row;
    logic [SB-1:0]              r_cur_row;
    logic [SB-1:0]              r_next_row;
    logic [AB-1:0]              r_cur_act;
    logic [ACTION_COUNT-1:0]    r_mask;
    logic [CB-1:0]              r_count;
    logic [CB-1:0]              r_rem;
    logic [CB-1:0]              r_seen;
    logic [DRW-1:0]             r_draw;
    logic [AB-1:0]              r_pick;
    logic                       r_explore;
    logic                       r_is_reward;
    logic                       r_newest;
    logic signed [15:0]         r_reward;
    logic                       r_pv;
    logic [AB-1:0]              r_pa;
    logic                       r_have;
    logic signed [Q_WIDTH-1:0]  r_best;
    logic [AB-1:0]              r_bact;
    logic [2:0]                 r_res_chosen;
    logic                       r_res_status;
    logic [5:0]                 r_res_updates;
    logic                       r_out_valid;
    logic [2:0]                 r_o_chosen;
    logic                       r_o_status;
    logic [5:0]                 r_o_updates;

    logic                       w_in_acc;
    logic                       w_cfg_wr;
    logic [ACTION_COUNT-1:0]    w_mask_raw;
    logic [ACTION_COUNT-1:0]    w_mask;
    logic [CB-1:0]              w_count;
    logic [SB-1:0]              w_row;
    logic [CB:0]                w_trial;
    logic [CB:0]                w_sub;
    logic                       w_ge;
    logic [AB-1:0]              w_a;
    logic [LB-1:0]              w_last;
    logic                       w_full;
    logic [AB-1:0]              w_choice;
    logic [QAW-1:0]             w_scan_addr;
    logic [QAW-1:0]             w_cur_addr;
    logic                       w_q_we;
    logic [QAW-1:0]             w_q_waddr;
    logic [Q_WIDTH-1:0]         w_q_wdata;
    logic [QAW-1:0]             w_q_raddr;
    logic [Q_WIDTH-1:0]         w_q_rdata_raw;
    logic signed [Q_WIDTH-1:0]  w_q_rdata;
    logic                       w_t_we;
    logic [TW-1:0]              w_t_rdata;
    qla_pkg::t_upd_ctl          w_upd_ctl;
    logic                       w_upd_done;
    logic signed [Q_WIDTH-1:0]  w_upd_q;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            qla_pkg::REG_LEARN_RATE:   prdata = 32'(r_learn_rate);
            qla_pkg::REG_DISCOUNT:     prdata = 32'(r_discount);
            qla_pkg::REG_EXPLORE_RATE: prdata = 32'(r_explore_rate);
            default:                   prdata = '0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_mask_raw = ACTION_COUNT'(i_legal_mask);
    assign w_mask     = (w_mask_raw == '0) ? '1 : w_mask_raw;

    always_comb begin
        w_count = '0;
        for (int a = 0; a < ACTION_COUNT; a++) begin
            w_count = w_count + CB'(w_mask[a]);
        end
    end

    assign w_row = (32'(i_current_state) >= STATE_COUNT) ? SB'(STATE_COUNT - 1)
                                                         : SB'(i_current_state);

    assign w_trial  = {r_rem, r_draw[DRW-1]};
    assign w_ge     = w_trial >= (CB + 1)'(r_count);
    assign w_sub    = w_trial - (CB + 1)'(r_count);
    assign w_a      = r_cnt[AB-1:0];
    assign w_last   = r_len - LB'(1);
    assign w_full   = (32'(r_len) >= HISTORY_DEPTH);
    assign w_choice = r_explore ? r_pick : r_bact;

    assign w_scan_addr = QAW'(r_row) * QAW'(ACTION_COUNT) + QAW'(w_a);
    assign w_cur_addr  = QAW'(r_cur_row) * QAW'(ACTION_COUNT) + QAW'(r_cur_act);
    assign w_q_raddr   = (r_state == S_RW_QRD) ? w_cur_addr : w_scan_addr;
    assign w_q_we      = (r_state == S_INIT) || ((r_state == S_RW_CALC) && w_upd_done);
    assign w_q_waddr   = (r_state == S_INIT) ? r_clr : w_cur_addr;
    assign w_q_wdata   = (r_state == S_INIT) ? '0 : w_upd_q;
    assign w_q_rdata   = w_q_rdata_raw;

    assign w_t_we = (r_state == S_REC) && !w_full;

    assign w_upd_ctl.start    = (r_state == S_RW_QWAIT);
    assign w_upd_ctl.has_next = !r_newest;
    assign w_upd_ctl.newest   = r_newest;

    qla_ram #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QD)
    ) u_q_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_re    (1'b1),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata_raw)
    );

    qla_ram #(
        .WIDTH (TW),
        .DEPTH (HISTORY_DEPTH)
    ) u_traj_ram (
        .i_clk   (i_clk),
        .i_we    (w_t_we),
        .i_waddr (r_len[HB-1:0]),
        .i_wdata ({r_row, w_choice}),
        .i_re    (1'b1),
        .i_raddr (r_step),
        .o_rdata (w_t_rdata)
    );

    qla_upd #(
        .Q_WIDTH (Q_WIDTH)
    ) u_upd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_upd_ctl),
        .i_cur    (w_q_rdata),
        .i_rmax   (r_best),
        .i_reward (r_reward),
        .i_alpha  (r_learn_rate),
        .i_gamma  (r_discount),
        .o_done   (w_upd_done),
        .o_q      (w_upd_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_clr          <= '0;
            r_len          <= '0;
            r_out_valid    <= 1'b0;
            r_pv           <= 1'b0;
            r_learn_rate   <= qla_pkg::LEARN_RATE_RST;
            r_discount     <= qla_pkg::DISCOUNT_RST;
            r_explore_rate <= qla_pkg::EXPLORE_RATE_RST;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    qla_pkg::REG_LEARN_RATE:   r_learn_rate   <= pwdata[15:0];
                    qla_pkg::REG_DISCOUNT:     r_discount     <= pwdata[15:0];
                    qla_pkg::REG_EXPLORE_RATE: r_explore_rate <= pwdata[15:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (r_pv) begin
                if (r_mask[r_pa] && (!r_have || w_q_rdata > r_best)) begin
                    r_best <= w_q_rdata;
                    r_bact <= r_pa;
                    r_have <= 1'b1;
                end
            end

            case (r_state)
                S_INIT: begin
                    r_clr <= r_clr + QAW'(1);
                    if (r_clr == QAW'(QD - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_res_chosen  <= '0;
                        r_res_status  <= 1'b0;
                        r_res_updates <= '0;
                        r_cnt         <= '0;
                        r_have        <= 1'b0;
                        r_pv          <= 1'b0;
                        case (i_action)
                            qla_pkg::OP_CHOOSE: begin
                                r_is_reward <= 1'b0;
                                r_row       <= w_row;
                                r_mask      <= w_mask;
                                r_count     <= w_count;
                                r_draw      <= i_explore_draw;
                                r_rem       <= '0;
                                r_seen      <= '0;
                                r_pick      <= '0;
                                r_explore   <= (i_explore_roll < r_explore_rate);
                                r_state     <= (i_explore_roll < r_explore_rate) ? S_DIV
                                                                                 : S_SCAN;
                            end
                            qla_pkg::OP_REWARD: begin
                                r_is_reward   <= 1'b1;
                                r_reward      <= i_reward_value;
                                r_newest      <= 1'b1;
                                r_step        <= w_last[HB-1:0];
                                r_res_updates <= (32'(r_len) > 63) ? 6'd63 : 6'(r_len);
                                r_len         <= '0;
                                r_state       <= (r_len == '0) ? S_DONE : S_RW_TRD;
                            end
                            qla_pkg::OP_CLEAR: begin
                                r_len   <= '0;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? w_sub[CB-1:0] : w_trial[CB-1:0];
                    r_draw <= {r_draw[DRW-2:0], 1'b0};
                    r_cnt  <= r_cnt + CW'(1);
                    if (r_cnt == CW'(DRW - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_mask[w_a]) begin
                        r_seen <= r_seen + CB'(1);
                        if (r_seen == r_rem) begin
                            r_pick  <= w_a;
                            r_state <= S_REC;
                        end
                    end
                    if (r_cnt == CW'(ACTION_COUNT - 1)) begin
                        r_state <= S_REC;
                    end
                end
                S_SCAN: begin
                    r_pv  <= 1'b1;
                    r_pa  <= w_a;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(ACTION_COUNT - 1)) begin
                        r_state <= S_SCAN_END;
                    end
                end
                S_SCAN_END: begin
                    r_pv    <= 1'b0;
                    r_state <= r_is_reward ? S_RW_QRD : S_REC;
                end
                S_REC: begin
                    r_res_chosen <= 3'(w_choice);
                    if (w_full) begin
                        r_res_status <= 1'b1;
                    end else begin
                        r_len <= r_len + LB'(1);
                    end
                    r_state <= S_DONE;
                end
                S_RW_TRD: begin
                    r_state <= S_RW_TWAIT;
                end
                S_RW_TWAIT: begin
                    r_cur_row <= w_t_rdata[TW-1:AB];
                    r_cur_act <= w_t_rdata[AB-1:0];
                    if (r_newest) begin
                        r_state <= S_RW_QRD;
                    end else begin
                        r_row   <= r_next_row;
                        r_mask  <= '1;
                        r_have  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_RW_QRD: begin
                    r_state <= S_RW_QWAIT;
                end
                S_RW_QWAIT: begin
                    r_state <= S_RW_CALC;
                end
                S_RW_CALC: begin
                    if (w_upd_done) begin
                        r_next_row <= r_cur_row;
                        r_newest   <= 1'b0;
                        if (r_step == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step  <= r_step - HB'(1);
                            r_state <= S_RW_TRD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_chosen  <= r_res_chosen;
                        r_o_status  <= r_res_status;
                        r_o_updates <= r_res_updates;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_action = r_o_chosen;
    assign o_status        = r_o_status;
    assign o_updates_done  = r_o_updates;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= HISTORY_DEPTH)
        else $error("History length exceeds its depth.");

    a_upd_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_done |-> (r_state == S_RW_CALC))
        else $error("Update result arrived outside the write-back state.");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("Result presented without finishing an item.");

    a_reward_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_action == qla_pkg::OP_REWARD)) |=> (r_len == '0))
        else $error("History not emptied by a reward transfer.");
`endif

endmodule
